// ----- rtl/core/lbc_pkg.sv -----
package lbc_pkg;

	localparam int SLOTS = 64;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic FUNC_ACQUIRE = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_MISS  = 3'd1;
	localparam logic [2:0] ST_ZERO  = 3'd2;
	localparam logic [2:0] ST_PAST  = 3'd3;
	localparam logic [2:0] ST_FULL  = 3'd4;
	localparam logic [2:0] ST_WRAP  = 3'd5;

	typedef struct packed {
		logic        func;
		logic [31:0] block_number;
		logic [5:0]  release_slot;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot;
		logic        write_back;
		logic [31:0] victim_block;
	} rsp_item_t;

	typedef struct packed {
		logic [31:0] tag;
		logic [31:0] stamp;
		logic [7:0]  pins;
	} entry_t;

	typedef struct packed {
		logic        inc;
		logic        dec;
		logic        set_tag;
		logic [31:0] tag;
		logic [31:0] stamp;
	} cell_op_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             found;
		logic [IDX_W-1:0] least_idx;
		logic             least_used;
		logic [31:0]      victim_tag;
	} scan_res_t;

endpackage

// ----- rtl/core/lbc_cell.sv -----
module lbc_cell
	import lbc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     shift,
	input  entry_t   nxt,
	input  logic     wr,
	input  cell_op_t op,
	output entry_t   cur
);

	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= nxt;
		end else if (wr) begin
			if (op.set_tag) begin
				entry_q.tag <= op.tag;
			end
			if (op.inc) begin
				entry_q.stamp <= op.stamp;
				if (entry_q.pins != 8'hFF) begin
					entry_q.pins <= entry_q.pins + 8'd1;
				end
			end else if (op.dec && entry_q.pins != 8'd0) begin
				entry_q.pins <= entry_q.pins - 8'd1;
			end
		end
	end

	assign cur = entry_q;

endmodule

// ----- rtl/core/lbc_scan.sv -----
module lbc_scan
	import lbc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             step,
	input  logic [IDX_W-1:0] idx,
	input  entry_t           head,
	input  logic [31:0]      num,
	output scan_res_t        res
);

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             found_q;
	logic [IDX_W-1:0] least_idx_q;
	logic [31:0]      least_stamp_q;
	logic [31:0]      victim_tag_q;
	logic             older;

	// strict compare keeps ties on the lowest slot
	assign older = (head.pins == 8'd0) && (!found_q || head.stamp < least_stamp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (start) begin
			hit_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (step) begin
			if (!hit_q && head.tag == num) begin
				hit_q <= 1'b1;
			end
			if (older) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (!hit_q && head.tag == num) begin
				hit_idx_q <= idx;
			end
			if (older) begin
				least_idx_q   <= idx;
				least_stamp_q <= head.stamp;
				victim_tag_q  <= head.tag;
			end
		end
	end

	assign res.hit        = hit_q;
	assign res.hit_idx    = hit_idx_q;
	assign res.found      = found_q;
	assign res.least_idx  = least_idx_q;
	assign res.least_used = (least_stamp_q != 32'd0);
	assign res.victim_tag = victim_tag_q;

endmodule

// ----- rtl/core/lru_block_cache_with_pins_core.sv -----
// Tag and replacement controller for a fully associative block cache with per-slot
// pin counts. Slot entries sit in a ring of cells; an acquire that passes the range
// checks rotates the ring once so every slot passes the compare head, one slot per
// cycle, then writes the chosen slot. An accepted item goes from decode to the finish
// state, through the scan and update states only for such an acquire; a new item
// is taken only back in idle. The result sits in an output register, so a stalled
// consumer does not hold up the scan of the next item.
module lru_block_cache_with_pins_core
	import lbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_item_t   req_data,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_item_t   rsp_data,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [31:0]      disk_count_q;
	logic [31:0]      use_clock_q;
	req_item_t        req_q;
	rsp_item_t        res_q;
	rsp_item_t        rsp_q;
	logic             rsp_valid_q;

	entry_t           cur [SLOTS];
	logic [SLOTS-1:0] sel;
	cell_op_t         op;
	logic             op_we;
	logic             op_rel;
	logic [IDX_W-1:0] pick;
	logic [31:0]      clock_nxt;
	logic             do_write;
	logic             shift;
	logic             scan_start;
	logic             fin_go;
	scan_res_t        scan;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign shift      = (state_q == S_SCAN);
	assign clock_nxt  = use_clock_q + 32'd1;
	assign pick       = scan.hit ? scan.hit_idx : scan.least_idx;
	assign do_write   = scan.hit || scan.found;
	assign fin_go     = (state_q == S_FIN) && (!rsp_valid_q || rsp_ready);
	assign scan_start = (state_q == S_DEC) && (req_q.func == FUNC_ACQUIRE)
		&& (req_q.block_number != 32'd0) && (req_q.block_number < disk_count_q);

	// cell write command
	always_comb begin
		op     = '0;
		op_we  = 1'b0;
		op_rel = 1'b0;
		unique case (state_q)
			S_DEC: begin
				if (req_q.func == FUNC_RELEASE) begin
					op_we  = 1'b1;
					op_rel = 1'b1;
					op.dec = 1'b1;
				end
			end
			S_UPD: begin
				op_we      = do_write;
				op.inc     = 1'b1;
				op.set_tag = !scan.hit;
				op.tag     = req_q.block_number;
				op.stamp   = clock_nxt;
			end
			default: begin
			end
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			assign sel[gi] = op_we && (op_rel ? (32'(req_q.release_slot) == 32'(gi))
				: (pick == IDX_W'(gi)));

			lbc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.nxt    (cur[(gi + 1) % SLOTS]),
				.wr     (sel[gi]),
				.op     (op),
				.cur    (cur[gi])
			);
		end
	endgenerate

	lbc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.step   (shift),
		.idx    (cnt_q),
		.head   (cur[0]),
		.num    (req_q.block_number),
		.res    (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_count_q <= 32'd5;
		end else if (cfg_wr_en) begin
			disk_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			use_clock_q <= 32'd1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					cnt_q   <= '0;
					state_q <= scan_start ? S_SCAN : S_FIN;
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (do_write) begin
						use_clock_q <= clock_nxt;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req_data;
		end
		if (state_q == S_DEC) begin
			res_q.slot         <= (req_q.func == FUNC_RELEASE) ? req_q.release_slot : 6'd0;
			res_q.write_back   <= 1'b0;
			res_q.victim_block <= 32'd0;
			if (req_q.func == FUNC_RELEASE) begin
				res_q.status <= ST_OK;
			end else if (req_q.block_number == 32'd0) begin
				res_q.status <= ST_ZERO;
			end else if (req_q.block_number >= disk_count_q) begin
				res_q.status <= ST_PAST;
			end else begin
				res_q.status <= ST_OK;
			end
		end else if (state_q == S_UPD) begin
			res_q.status       <= !do_write ? ST_FULL
				: ((clock_nxt == 32'd0) ? ST_WRAP : (scan.hit ? ST_OK : ST_MISS));
			res_q.slot         <= do_write ? 6'(pick) : 6'd0;
			res_q.write_back   <= do_write && !scan.hit && scan.least_used;
			res_q.victim_block <= (do_write && !scan.hit) ? scan.victim_tag : 32'd0;
		end
		if (fin_go) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// the use stamp only moves when a slot is written
	a_clock_moves_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_UPD) |=> $stable(use_clock_q))
		else $error("use stamp changed outside update");

	a_accept_goes_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_DEC))
		else $error("accepted item did not reach decode");

	a_zero_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEC && req_q.func == FUNC_ACQUIRE && req_q.block_number == 32'd0)
		|=> (res_q.status == ST_ZERO && state_q == S_FIN))
		else $error("block zero not rejected");

	a_miss_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && !scan.hit && scan.found)
		|=> (res_q.status == ST_MISS || res_q.status == ST_WRAP))
		else $error("miss fill reported wrong status");

	a_scan_only_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (req_q.func == FUNC_ACQUIRE && req_q.block_number != 32'd0))
		else $error("scan running for a rejected item");

endmodule
